/* rtl/spa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the sparse polynomial adder.
// Depends on nothing; every other file of the block imports it.
package spa_pkg;

	// Operation codes carried in the request transaction.
	localparam logic [1:0] OP_INSERT_P = 2'd0;
	localparam logic [1:0] OP_INSERT_Q = 2'd1;
	localparam logic [1:0] OP_SUM      = 2'd2;

	// Status codes carried in the response transaction.
	localparam logic [1:0] STS_TERM      = 2'd0;
	localparam logic [1:0] STS_INSERT_OK = 2'd1;
	localparam logic [1:0] STS_FULL      = 2'd2;
	localparam logic [1:0] STS_EMPTY     = 2'd3;

	// Saturation limits of a Q16.16 coefficient.
	localparam logic signed [31:0] COEF_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] coefficient;
		logic signed [15:0] exponent;
	} spa_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_coefficient;
		logic signed [15:0] result_exponent;
		logic               last;
	} spa_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SUM
	} spa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the request and set up the walk
		logic sum_mode;    // table read ports follow the merge heads
		logic ins_shift;   // move one entry down one place
		logic ins_place;   // write the new term and report success
		logic emit_full;   // report a dropped term
		logic emit_empty;  // report an empty sum
		logic sum_step;    // emit one merged term
	} spa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;        // chosen table has no free entry
		logic hit;         // insert position reached
		logic both_empty;  // both tables hold no term
		logic sum_last;    // current merge step is the final one
		logic out_free;    // response register can take a transaction
	} spa_stat_t;

endpackage

/* rtl/spa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the sparse polynomial adder.
// Depends on spa_pkg for the state, command and status types.
module spa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_op,
	input  spa_pkg::spa_stat_t stat,
	output spa_pkg::spa_cmd_t  cmd,
	output logic              req_stall
);
	import spa_pkg::*;

	spa_state_t state_q;
	spa_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (req_op == OP_INSERT_P || req_op == OP_INSERT_Q) begin
						state_nxt = ST_INSERT;
					end else if (req_op == OP_SUM) begin
						state_nxt = ST_SUM;
					end
				end
			end
			ST_INSERT: begin
				priority if (stat.full) begin
					if (stat.out_free) begin
						cmd.emit_full = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else if (stat.hit) begin
					if (stat.out_free) begin
						cmd.ins_place = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else begin
					cmd.ins_shift = 1'b1;
				end
			end
			ST_SUM: begin
				cmd.sum_mode = 1'b1;
				if (stat.out_free) begin
					if (stat.both_empty) begin
						cmd.emit_empty = 1'b1;
						state_nxt      = ST_IDLE;
					end else begin
						cmd.sum_step = 1'b1;
						if (stat.sum_last) begin
							state_nxt = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/spa_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the sparse polynomial adder: term tables, counts, walk
// indexes, saturating adder and the response register. Depends on spa_pkg.
module spa_datapath #(
	parameter int MAX_TERMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spa_pkg::spa_req_t req,
	input  spa_pkg::spa_cmd_t cmd,
	output spa_pkg::spa_stat_t stat,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output spa_pkg::spa_rsp_t rsp
);
	import spa_pkg::*;

	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TERMS);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	// Term tables; contents are only used below the fill count.
	logic signed [31:0] p_coef_q [MAX_TERMS];
	logic signed [15:0] p_expo_q [MAX_TERMS];
	logic signed [31:0] q_coef_q [MAX_TERMS];
	logic signed [15:0] q_expo_q [MAX_TERMS];

	logic [CW-1:0]      p_cnt_q, q_cnt_q;
	logic [CW-1:0]      idx_q, ip_q, iq_q;
	logic               sel_q;
	logic signed [31:0] coef_q;
	logic signed [15:0] expo_q;
	logic               rsp_valid_q;
	spa_rsp_t           rsp_q;

	logic [CW-1:0]      idx_m1;
	logic [IW-1:0]      p_raddr, q_raddr, widx;
	logic signed [31:0] p_rd_c, q_rd_c, rd_c, wr_c;
	logic signed [15:0] p_rd_e, q_rd_e, rd_e, wr_e;
	logic [CW-1:0]      tcnt;
	logic               p_we, q_we;
	logic               p_exh, q_exh, take_p, take_q;
	logic [CW-1:0]      ip_nxt, iq_nxt;
	logic signed [32:0] wide_sum;
	logic signed [31:0] sat_sum, merge_c;
	logic               any_emit;
	spa_rsp_t           rsp_nxt;

	// Table read ports: merge heads during a sum, the entry above the
	// insert slot otherwise.
	assign idx_m1  = idx_q - CNT_ONE;
	assign p_raddr = cmd.sum_mode ? ip_q[IW-1:0] : idx_m1[IW-1:0];
	assign q_raddr = cmd.sum_mode ? iq_q[IW-1:0] : idx_m1[IW-1:0];
	assign p_rd_c  = p_coef_q[p_raddr];
	assign p_rd_e  = p_expo_q[p_raddr];
	assign q_rd_c  = q_coef_q[q_raddr];
	assign q_rd_e  = q_expo_q[q_raddr];
	assign rd_c    = sel_q ? q_rd_c : p_rd_c;
	assign rd_e    = sel_q ? q_rd_e : p_rd_e;
	assign tcnt    = sel_q ? q_cnt_q : p_cnt_q;

	// Insert walk: stop at the first slot or once the entry above holds an exponent not below ours.
	assign stat.full = (tcnt == CNT_FULL);
	assign stat.hit  = (idx_q == '0) || (rd_e >= expo_q);

	// One write port per table.
	assign widx = idx_q[IW-1:0];
	assign wr_c = cmd.ins_place ? coef_q : rd_c;
	assign wr_e = cmd.ins_place ? expo_q : rd_e;
	assign p_we = (cmd.ins_shift || cmd.ins_place) && !sel_q;
	assign q_we = (cmd.ins_shift || cmd.ins_place) && sel_q;

	always_ff @(posedge clk) begin
		if (p_we) begin
			p_coef_q[widx] <= wr_c;
			p_expo_q[widx] <= wr_e;
		end
		if (q_we) begin
			q_coef_q[widx] <= wr_c;
			q_expo_q[widx] <= wr_e;
		end
	end

	// Merge head selection and saturating add.
	assign p_exh    = (ip_q == p_cnt_q);
	assign q_exh    = (iq_q == q_cnt_q);
	assign take_p   = q_exh || (!p_exh && (p_rd_e > q_rd_e));
	assign take_q   = !take_p && (p_exh || (q_rd_e > p_rd_e));
	assign wide_sum = {p_rd_c[31], p_rd_c} + {q_rd_c[31], q_rd_c};

	always_comb begin
		if (wide_sum[32] != wide_sum[31]) begin
			sat_sum = wide_sum[32] ? COEF_MIN : COEF_MAX;
		end else begin
			sat_sum = wide_sum[31:0];
		end
	end

	assign merge_c = take_p ? p_rd_c : (take_q ? q_rd_c : sat_sum);
	assign ip_nxt  = take_q ? ip_q : ip_q + CNT_ONE;
	assign iq_nxt  = take_p ? iq_q : iq_q + CNT_ONE;

	assign stat.sum_last   = (ip_nxt == p_cnt_q) && (iq_nxt == q_cnt_q);
	assign stat.both_empty = (p_cnt_q == '0) && (q_cnt_q == '0);
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	// Fill counts, captured table select and walk indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_cnt_q <= '0;
			q_cnt_q <= '0;
			idx_q   <= '0;
			ip_q    <= '0;
			iq_q    <= '0;
			sel_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				sel_q <= (req.operation == OP_INSERT_Q);
				idx_q <= (req.operation == OP_INSERT_Q) ? q_cnt_q : p_cnt_q;
				ip_q  <= '0;
				iq_q  <= '0;
			end
			if (cmd.ins_shift) begin
				idx_q <= idx_m1;
			end
			if (cmd.ins_place) begin
				if (sel_q) begin
					q_cnt_q <= q_cnt_q + CNT_ONE;
				end else begin
					p_cnt_q <= p_cnt_q + CNT_ONE;
				end
			end
			if (cmd.sum_step) begin
				ip_q <= ip_nxt;
				iq_q <= iq_nxt;
				if (stat.sum_last) begin
					p_cnt_q <= '0;
					q_cnt_q <= '0;
				end
			end
		end
	end

	// Payload of the request; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coef_q <= req.coefficient;
			expo_q <= req.exponent;
		end
	end

	// Next response transaction.
	assign any_emit = cmd.ins_place || cmd.emit_full || cmd.emit_empty || cmd.sum_step;

	always_comb begin
		rsp_nxt      = '0;
		rsp_nxt.last = 1'b1;
		priority if (cmd.sum_step) begin
			rsp_nxt.status             = STS_TERM;
			rsp_nxt.result_coefficient = merge_c;
			rsp_nxt.result_exponent    = take_q ? q_rd_e : p_rd_e;
			rsp_nxt.last               = stat.sum_last;
		end else if (cmd.ins_place) begin
			rsp_nxt.status = STS_INSERT_OK;
		end else if (cmd.emit_full) begin
			rsp_nxt.status = STS_FULL;
		end else begin
			rsp_nxt.status = STS_EMPTY;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (any_emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (any_emit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/sparse_polynomial_adder_unit.sv */
`timescale 1ns / 1ps
// Top level of the sparse polynomial adder: controller plus datapath.
// Depends on spa_pkg, spa_ctrl and spa_datapath.
//
//   Channel  Signals                        Content
//   request  req_valid, req_stall, req      operation, coefficient, exponent
//   response rsp_valid, rsp_stall, rsp      status, result_coefficient,
//                                           result_exponent, last
//
// An insert shifts each stored term with a smaller exponent down one place,
// one table entry per cycle, then writes the new term into the freed slot.
// A sum emits one merged term per merge step, one merge step per cycle while
// the response register is free, so at most 2*MAX_TERMS terms; an empty sum emits a single empty status.
// Reset empties both tables at once; no clearing pass is needed.
// A stalled response holds each merge step of a sum, and the final write of
// an insert, until the response register frees up; insert shifts go on.
module sparse_polynomial_adder_unit #(
	parameter int MAX_TERMS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spa_pkg::spa_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spa_pkg::spa_rsp_t rsp
);
	import spa_pkg::*;

	spa_cmd_t  cmd;
	spa_stat_t stat;

	spa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	spa_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	// A response is only produced when the response register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_place || cmd.emit_full || cmd.emit_empty || cmd.sum_step)
		|-> stat.out_free)
		else $error("response produced while the response register is occupied");

	// At most one table or response action per cycle.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.ins_shift, cmd.ins_place, cmd.emit_full,
			cmd.emit_empty, cmd.sum_step}))
		else $error("conflicting datapath commands");

	// The final merge step leaves both tables empty.
	a_sum_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sum_step && stat.sum_last) |=> stat.both_empty)
		else $error("tables not cleared after a sum");

	// New requests are taken only while the datapath is idle.
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_shift || cmd.sum_step) |-> req_stall)
		else $error("request accepted during a walk");

endmodule

/* dv/sparse_polynomial_adder_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sparse_polynomial_adder_unit: inserts and sums under random idling.
// A behavioral copy of both term tables predicts every response transaction.
// Depends on spa_pkg and the sparse_polynomial_adder_unit RTL.
module sparse_polynomial_adder_unit_test;
	import spa_pkg::*;

	localparam int MAX_TERMS = 16;
	// The fourth operation code has no meaning and must be ignored.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int TABLE_P = 0;
	localparam int TABLE_Q = 1;

	typedef enum int {
		STALL_NONE,
		STALL_SPARSE,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	spa_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	spa_rsp_t rsp;

	sparse_polynomial_adder_unit #(
		.MAX_TERMS(MAX_TERMS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of both term tables, index TABLE_P or TABLE_Q.
	logic signed [31:0] table_coef [2][MAX_TERMS];
	logic signed [15:0] table_expo [2][MAX_TERMS];
	int                 table_count [2] = '{0, 0};
	spa_rsp_t           awaited_rsp [$];
	int                 mismatch_count = 0;
	int                 burst_left = 0;

	function automatic spa_rsp_t make_rsp(logic [1:0] status, logic signed [31:0] coef,
			logic signed [15:0] expo, logic last);
		spa_rsp_t r;
		r.status             = status;
		r.result_coefficient = coef;
		r.result_exponent    = expo;
		r.last               = last;
		return r;
	endfunction

	function automatic spa_req_t make_req(logic [1:0] op, logic signed [31:0] coef,
			logic signed [15:0] expo);
		spa_req_t r;
		r.operation   = op;
		r.coefficient = coef;
		r.exponent    = expo;
		return r;
	endfunction

	// Apply one accepted request to the shadow tables and queue the responses it causes.
	function automatic void apply_term_request(spa_req_t item);
		int                 t;
		int                 pos;
		int                 i;
		int                 ip;
		int                 iq;
		longint             wide;
		logic signed [31:0] c;
		logic signed [15:0] e;
		case (item.operation)
			OP_INSERT_P, OP_INSERT_Q: begin
				t = (item.operation == OP_INSERT_P) ? TABLE_P : TABLE_Q;
				if (table_count[t] >= MAX_TERMS) begin
					awaited_rsp.push_back(make_rsp(STS_FULL, '0, '0, 1'b1));
				end else begin
					// The new term goes after every term with an equal or larger exponent.
					pos = 0;
					while (pos < table_count[t] && table_expo[t][pos] >= item.exponent)
						pos++;
					for (i = table_count[t]; i > pos; i--) begin
						table_coef[t][i] = table_coef[t][i-1];
						table_expo[t][i] = table_expo[t][i-1];
					end
					table_coef[t][pos] = item.coefficient;
					table_expo[t][pos] = item.exponent;
					table_count[t]++;
					awaited_rsp.push_back(make_rsp(STS_INSERT_OK, '0, '0, 1'b1));
				end
			end
			OP_SUM: begin
				if (table_count[TABLE_P] == 0 && table_count[TABLE_Q] == 0) begin
					awaited_rsp.push_back(make_rsp(STS_EMPTY, '0, '0, 1'b1));
				end else begin
					ip = 0;
					iq = 0;
					// Merge head to head; equal heads pair up and add with saturation.
					while (ip < table_count[TABLE_P] || iq < table_count[TABLE_Q]) begin
						if (iq >= table_count[TABLE_Q] || (ip < table_count[TABLE_P] &&
								table_expo[TABLE_P][ip] > table_expo[TABLE_Q][iq])) begin
							c = table_coef[TABLE_P][ip];
							e = table_expo[TABLE_P][ip];
							ip++;
						end else if (ip >= table_count[TABLE_P] ||
								table_expo[TABLE_Q][iq] > table_expo[TABLE_P][ip]) begin
							c = table_coef[TABLE_Q][iq];
							e = table_expo[TABLE_Q][iq];
							iq++;
						end else begin
							wide = longint'(table_coef[TABLE_P][ip]) +
								longint'(table_coef[TABLE_Q][iq]);
							if (wide > longint'(COEF_MAX))
								c = COEF_MAX;
							else if (wide < longint'(COEF_MIN))
								c = COEF_MIN;
							else
								c = wide[31:0];
							e = table_expo[TABLE_P][ip];
							ip++;
							iq++;
						end
						awaited_rsp.push_back(make_rsp(STS_TERM, c, e,
							ip >= table_count[TABLE_P] && iq >= table_count[TABLE_Q]));
					end
					table_count[TABLE_P] = 0;
					table_count[TABLE_Q] = 0;
				end
			end
			default: begin
				// Unused operation code: no state change, no response.
			end
		endcase
	endfunction

	// Send one request transaction; the sender runs in bursts separated by random gaps.
	task automatic send_item(spa_req_t item);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		apply_term_request(item);
	endtask

	// Hold off the sender until every awaited response has arrived.
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_exponent();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom_range(0, 16'hFFFF));
		return 16'(int'($urandom_range(0, 6)) - 3);
	endfunction

	function automatic logic signed [31:0] random_coefficient();
		case ($urandom_range(0, 7))
			0: return COEF_MAX - $urandom_range(0, 3);
			1: return COEF_MIN + $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// Receiver stall pattern: a mode is held for a random stretch of cycles.
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_phase = 0;
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			stall_mode  <= stall_mode_t'($urandom_range(0, 3));
			stall_phase <= $urandom_range(16, 96);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			STALL_NONE:     rsp_stall <= 1'b0;
			STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: rsp_stall <= ((stall_phase % 8) < 3);
			default:        rsp_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s expected %h actual %h", $time, field, want, got);
		mismatch_count++;
	endtask

	// Compare every accepted response transaction with the oldest awaited one.
	always @(posedge clk) begin
		spa_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time, rsp);
				mismatch_count++;
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status)
					report_field("status", 32'(want.status), 32'(rsp.status));
				if (rsp.result_coefficient !== want.result_coefficient)
					report_field("result_coefficient", want.result_coefficient,
						rsp.result_coefficient);
				if (rsp.result_exponent !== want.result_exponent)
					report_field("result_exponent", 32'(want.result_exponent),
						32'(rsp.result_exponent));
				if (rsp.last !== want.last)
					report_field("last", 32'(want.last), 32'(rsp.last));
			end
		end
	end

	// An unused code must leave the tables empty, so the following sum reports an empty sum.
	task automatic test_ignored_and_empty();
		send_item(make_req(OP_UNUSED, random_coefficient(), random_exponent()));
		send_item(make_req(OP_SUM, '0, '0));
		wait_idle();
	endtask

	// Fill P with extreme and duplicate exponents, then overflow it by one term.
	task automatic test_fill_and_overflow();
		logic signed [15:0] fill_expo [MAX_TERMS+1] = '{16'sh7FFF, 16'sh8000, 0, 0, 7, 7,
			5, -5, 3, 3, 1, -1, 2, -2, 12, -12, 4};
		logic signed [31:0] fill_coef [MAX_TERMS+1] = '{32'sh0001_0000, 32'shFFFF_0000,
			100, 9, -1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_8000, -3,
			32'sh5555_5555, 32'shAAAA_AAAA, 0, 42, -42, 32'sh1234_5678, 77};
		int k;
		for (k = 0; k <= MAX_TERMS; k++)
			send_item(make_req(OP_INSERT_P, fill_coef[k], fill_expo[k]));
	endtask

	// Q terms hit saturation both ways, a zero sum, an unmatched duplicate, and P running out first.
	task automatic test_merge_saturation();
		send_item(make_req(OP_INSERT_Q, COEF_MAX, 5));
		send_item(make_req(OP_INSERT_Q, COEF_MIN, -5));
		send_item(make_req(OP_INSERT_Q, -100, 0));
		send_item(make_req(OP_INSERT_Q, 2, 7));
		send_item(make_req(OP_INSERT_Q, 5, 16'sh8000));
		send_item(make_req(OP_INSERT_Q, 8, 16'sh8000));
		send_item(make_req(OP_SUM, '0, '0));
		wait_idle();
	endtask

	// Rounds of inserts into both tables followed by a sum, with noise and broken rounds.
	task automatic test_random_traffic();
		int sent;
		int n_p;
		int n_q;
		sent = 0;
		while (sent < 100) begin
			if ($urandom_range(0, 9) == 0)
				send_item(make_req(OP_UNUSED, random_coefficient(), random_exponent()));
			if ($urandom_range(0, 11) == 0) begin
				n_p = $urandom_range(0, MAX_TERMS + 1);
				n_q = $urandom_range(0, MAX_TERMS + 1);
			end else begin
				n_p = $urandom_range(0, 5);
				n_q = $urandom_range(0, 5);
			end
			while (n_p > 0 || n_q > 0) begin
				if (n_q == 0 || (n_p > 0 && $urandom_range(0, 1) == 0)) begin
					send_item(make_req(OP_INSERT_P, random_coefficient(), random_exponent()));
					n_p--;
				end else begin
					send_item(make_req(OP_INSERT_Q, random_coefficient(), random_exponent()));
					n_q--;
				end
				sent++;
			end
			// Now and then a round carries over into the next one without a sum.
			if ($urandom_range(0, 7) != 0) begin
				send_item(make_req(OP_SUM, '0, '0));
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				wait_idle();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_ignored_and_empty();
		test_fill_and_overflow();
		test_merge_saturation();
		test_random_traffic();
		wait_idle();
		repeat (2 * MAX_TERMS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

/* sparse_polynomial_adder_unit.f */
rtl/spa_pkg.sv
rtl/spa_ctrl.sv
rtl/spa_datapath.sv
rtl/sparse_polynomial_adder_unit.sv
dv/sparse_polynomial_adder_unit_test.sv
